>>> sv/sorted_list_insert_delete_defines.svh
// Assertion macros for the sorted list block.
`ifndef SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SLI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SLI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define SLI_ASSERT(label, prop, msg)
`define SLI_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> sv/sli_pkg.sv
// Types and codes shared by the sorted list controller and datapath.
`default_nettype none
package sli_pkg;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_DELETE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_INSERTED  = 2'd0,
		STAT_DELETED   = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic load;
		logic rd_prev;
		logic rd_cur;
		logic rd_next;
		logic idx_dec;
		logic idx_inc;
		logic wr_rdata;
		logic wr_value;
		logic cnt_inc;
		logic cnt_dec;
	} dp_ctl_t;

	typedef struct packed {
		logic is_delete;
		logic full;
		logic empty;
		logic idx_zero;
		logic last;
		logic ge;
		logic eq;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> sv/sli_ram.sv
// Generic RAM with one write port and one registered read port.
`default_nettype none
module sli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> sv/sli_ctrl.sv
// Controller state machine sequencing search and shift for insert and delete.
`default_nettype none
`include "sorted_list_insert_delete_defines.svh"
module sli_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   done,
	output logic [1:0]             status,
	input  wire sli_pkg::dp_stat_t st,
	output sli_pkg::dp_ctl_t       ctl
);
	import sli_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_RD_I,
		ST_WAIT_I,
		ST_WRITE_V,
		ST_RD_D,
		ST_WAIT_D,
		ST_SHIFT_D,
		ST_WAIT_S
	} state_t;

	state_t  state_q, state_d;
	logic    done_q, resp;
	status_t status_q, resp_code;

	always_comb begin
		ctl       = '0;
		state_d   = state_q;
		resp      = 1'b0;
		resp_code = STAT_INSERTED;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!st.is_delete) begin
					if (st.full) begin
						resp      = 1'b1;
						resp_code = STAT_FULL;
						state_d   = ST_IDLE;
					end else begin
						state_d = ST_RD_I;
					end
				end else if (st.empty) begin
					resp      = 1'b1;
					resp_code = STAT_NOT_FOUND;
					state_d   = ST_IDLE;
				end else begin
					state_d = ST_RD_D;
				end
			end
			ST_RD_I: begin
				if (st.idx_zero) begin
					state_d = ST_WRITE_V;
				end else begin
					ctl.rd_prev = 1'b1;
					state_d     = ST_WAIT_I;
				end
			end
			ST_WAIT_I: begin
				if (st.ge) begin
					ctl.wr_rdata = 1'b1;
					ctl.idx_dec  = 1'b1;
					state_d      = ST_RD_I;
				end else begin
					state_d = ST_WRITE_V;
				end
			end
			ST_WRITE_V: begin
				ctl.wr_value = 1'b1;
				ctl.cnt_inc  = 1'b1;
				resp         = 1'b1;
				resp_code    = STAT_INSERTED;
				state_d      = ST_IDLE;
			end
			ST_RD_D: begin
				ctl.rd_cur = 1'b1;
				state_d    = ST_WAIT_D;
			end
			ST_WAIT_D: begin
				if (st.eq) begin
					state_d = ST_SHIFT_D;
				end else if (st.last) begin
					resp      = 1'b1;
					resp_code = STAT_NOT_FOUND;
					state_d   = ST_IDLE;
				end else begin
					ctl.idx_inc = 1'b1;
					state_d     = ST_RD_D;
				end
			end
			ST_SHIFT_D: begin
				if (st.last) begin
					ctl.cnt_dec = 1'b1;
					resp        = 1'b1;
					resp_code   = STAT_DELETED;
					state_d     = ST_IDLE;
				end else begin
					ctl.rd_next = 1'b1;
					state_d     = ST_WAIT_S;
				end
			end
			ST_WAIT_S: begin
				ctl.wr_rdata = 1'b1;
				ctl.idx_inc  = 1'b1;
				state_d      = ST_SHIFT_D;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			status_q <= STAT_INSERTED;
		end else begin
			state_q <= state_d;
			done_q  <= resp;
			if (resp) begin
				status_q <= resp_code;
			end
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign status = status_q;

	`SLI_ASSERT(a_done_idle, done_q |-> (state_q == ST_IDLE), "result shown while busy")
	`SLI_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe held two cycles")

endmodule
`default_nettype wire

>>> sv/sli_dp.sv
// Datapath: entry RAM, scan index, entry count and compares.
`default_nettype none
`include "sorted_list_insert_delete_defines.svh"
module sli_dp #(
	parameter int CAPACITY = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd,
	input  wire logic signed [7:0] value,
	input  wire sli_pkg::dp_ctl_t  ctl,
	output sli_pkg::dp_stat_t      st,
	output logic [4:0]             entry_count
);
	import sli_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [AW-1:0]      idx_q;
	logic [CW-1:0]      count_q;
	logic signed [7:0]  value_q;
	cmd_t               cmd_q;
	logic [AW-1:0]      raddr;
	logic [7:0]         rdata;
	logic [7:0]         wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			cmd_q   <= CMD_INSERT;
		end else begin
			if (ctl.load) begin
				cmd_q <= cmd_t'(cmd);
				idx_q <= (cmd_t'(cmd) == CMD_DELETE) ? '0 : count_q[AW-1:0];
			end else if (ctl.idx_dec) begin
				idx_q <= idx_q - AW'(1);
			end else if (ctl.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
			if (ctl.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			value_q <= value;
		end
	end

	always_comb begin
		priority if (ctl.rd_prev) begin
			raddr = idx_q - AW'(1);
		end else if (ctl.rd_next) begin
			raddr = idx_q + AW'(1);
		end else begin
			raddr = idx_q;
		end
	end

	assign wdata = ctl.wr_value ? value_q : rdata;

	sli_ram #(
		.WIDTH(8),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ctl.wr_rdata | ctl.wr_value),
		.waddr(idx_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign st.is_delete = (cmd_q == CMD_DELETE);
	assign st.full      = (count_q == CW'(CAPACITY));
	assign st.empty     = (count_q == '0);
	assign st.idx_zero  = (idx_q == '0);
	assign st.last      = ((CW'(idx_q) + CW'(1)) == count_q);
	assign st.ge        = ($signed(rdata) >= value_q);
	assign st.eq        = ($signed(rdata) == value_q);

	assign entry_count = 5'(count_q);

	`SLI_ASSERT(a_cnt_bound, count_q <= CW'(CAPACITY), "entry count above capacity")
	`SLI_ASSERT(a_wr_range, (ctl.wr_rdata | ctl.wr_value) |-> (CW'(idx_q) <= count_q), "write past end")
	`SLI_ASSERT_NEXT(a_cnt_inc, ctl.cnt_inc, count_q == $past(count_q) + CW'(1), "count not advanced on insert")
	`SLI_ASSERT(a_rd_one, $onehot0({ctl.rd_prev, ctl.rd_cur, ctl.rd_next}), "more than one read select")

endmodule
`default_nettype wire

>>> sv/sorted_list_insert_delete.sv
// Top level of the sorted bounded list of signed 8-bit entries.
//
//  channel  | handshake          | ports
//  ---------+--------------------+----------------------
//  command  | start & !busy      | cmd, value
//  result   | done (one cycle)   | status, entry_count
//
// Full insert or empty delete: result straight from the decide state, no RAM access.
// Insert shifts entries up from the end, one read and one write per entry moved;
// delete scans up from position 0 for the value, then shifts the entries above
// it down; both are paced by the one registered read port of the entry RAM.
// Reset clears the count; the entry RAM is not cleared and needs no sweep.
// The receiver cannot stall; busy holds off commands until the word is done.
`default_nettype none
module sorted_list_insert_delete #(
	parameter int CAPACITY = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              cmd,
	input  wire logic signed [7:0] value,
	output logic                   done,
	output logic [1:0]             status,
	output logic [4:0]             entry_count
);
	import sli_pkg::*;

	dp_ctl_t  ctl;
	dp_stat_t st;

	sli_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.status(status),
		.st    (st),
		.ctl   (ctl)
	);

	sli_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (value),
		.ctl        (ctl),
		.st         (st),
		.entry_count(entry_count)
	);

endmodule
`default_nettype wire

>>> verif/tb_sorted_list_insert_delete.sv
// Self-checking testbench for the sorted list block: directed table, then random words.
`default_nettype none
module tb_sorted_list_insert_delete;
	timeunit 1ns;
	timeprecision 1ps;

	import sli_pkg::*;

	localparam int CAPACITY = 16;
	localparam int N_ROWS = 24;
	localparam int RANDOM_PER_PHASE = 100;
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

	typedef struct {
		status_t    st;
		logic [4:0] cnt;
	} outcome_t;

	typedef struct {
		cmd_t              op;
		logic signed [7:0] val;
		int                reps;
		bit                typed;
		status_t           st;
		logic [4:0]        cnt;
	} plan_row_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              cmd = CMD_INSERT;
	logic signed [7:0] value = 8'h00;
	logic              busy;
	logic              done;
	logic [1:0]        status;
	logic [4:0]        entry_count;

	logic signed [7:0] sorted_copy[$];
	outcome_t          awaited_results[$];
	plan_row_t         directed_plan [0:N_ROWS-1];
	int                mismatches = 0;

	sorted_list_insert_delete #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.value(value),
		.done(done),
		.status(status),
		.entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("%0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic outcome_t predict_list_op(input cmd_t op, input logic signed [7:0] v);
		outcome_t res;
		int pos;
		pos = 0;
		if (op == CMD_INSERT) begin
			if (sorted_copy.size() >= CAPACITY) begin
				res.st = STAT_FULL;
			end else begin
				while (pos < sorted_copy.size() && v > sorted_copy[pos])
					pos++;
				sorted_copy.insert(pos, v);
				res.st = STAT_INSERTED;
			end
		end else begin
			while (pos < sorted_copy.size() && sorted_copy[pos] != v)
				pos++;
			if (pos >= sorted_copy.size()) begin
				res.st = STAT_NOT_FOUND;
			end else begin
				sorted_copy.delete(pos);
				res.st = STAT_DELETED;
			end
		end
		res.cnt = 5'(sorted_copy.size());
		return res;
	endfunction

	// hold the word until accepted, then record what it must return
	task automatic send_word(input cmd_t op, input logic signed [7:0] v, input int idle_pct,
			input bit typed, input status_t st, input logic [4:0] cnt);
		int gap;
		outcome_t res;
		gap = 0;
		while ($urandom_range(99) < idle_pct && gap < 60)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		value <= v;
		do @(posedge clk); while (busy);
		res = predict_list_op(op, v);
		if (typed) begin
			res.st = st;
			res.cnt = cnt;
		end
		awaited_results.push_back(res);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected word status=%0d count=%0d",
					status, entry_count));
			end else begin
				outcome_t exp_res;
				exp_res = awaited_results.pop_front();
				if (status !== exp_res.st)
					report_mismatch($sformatf("status %0d, want %0d", status, exp_res.st));
				if (entry_count !== exp_res.cnt)
					report_mismatch($sformatf("entry_count %0d, want %0d",
						entry_count, exp_res.cnt));
			end
		end
	end

	initial begin
		int idle_by_phase [4];
		bit growing;
		cmd_t op;
		logic signed [7:0] v;

		idle_by_phase = '{0, 88, 0, 38};
		directed_plan = '{
			'{CMD_DELETE, 8'h00,  1, 1'b1, STAT_NOT_FOUND, 5'd0},
			'{CMD_DELETE, 8'h80,  1, 1'b1, STAT_NOT_FOUND, 5'd0},
			'{CMD_INSERT, 8'h7F,  1, 1'b1, STAT_INSERTED,  5'd1},
			'{CMD_INSERT, 8'h80,  1, 1'b1, STAT_INSERTED,  5'd2},
			'{CMD_INSERT, 8'h00,  1, 1'b1, STAT_INSERTED,  5'd3},
			'{CMD_INSERT, 8'h00,  1, 1'b1, STAT_INSERTED,  5'd4},
			'{CMD_DELETE, 8'h05,  1, 1'b1, STAT_NOT_FOUND, 5'd4},
			'{CMD_DELETE, 8'h00,  1, 1'b1, STAT_DELETED,   5'd3},
			'{CMD_DELETE, 8'h00,  1, 1'b1, STAT_DELETED,   5'd2},
			'{CMD_DELETE, 8'h00,  1, 1'b1, STAT_NOT_FOUND, 5'd2},
			'{CMD_DELETE, 8'h7F,  1, 1'b1, STAT_DELETED,   5'd1},
			'{CMD_INSERT, 8'hFF,  1, 1'b1, STAT_INSERTED,  5'd2},
			'{CMD_INSERT, 8'h40, 13, 1'b0, STAT_INSERTED,  5'd0},
			'{CMD_INSERT, 8'h7F,  1, 1'b1, STAT_INSERTED,  5'd16},
			'{CMD_INSERT, 8'h80,  1, 1'b1, STAT_FULL,      5'd16},
			'{CMD_INSERT, 8'h00,  1, 1'b1, STAT_FULL,      5'd16},
			'{CMD_DELETE, 8'h7F,  1, 1'b1, STAT_DELETED,   5'd15},
			'{CMD_INSERT, 8'hFE,  1, 1'b1, STAT_INSERTED,  5'd16},
			'{CMD_DELETE, 8'h40, 13, 1'b0, STAT_DELETED,   5'd0},
			'{CMD_DELETE, 8'hFF,  1, 1'b1, STAT_DELETED,   5'd2},
			'{CMD_DELETE, 8'h80,  1, 1'b1, STAT_DELETED,   5'd1},
			'{CMD_DELETE, 8'hFE,  1, 1'b1, STAT_DELETED,   5'd0},
			'{CMD_DELETE, 8'hFE,  1, 1'b1, STAT_NOT_FOUND, 5'd0},
			'{CMD_INSERT, 8'h00,  1, 1'b1, STAT_INSERTED,  5'd1}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[r])
			repeat (directed_plan[r].reps)
				send_word(directed_plan[r].op, directed_plan[r].val, 0,
					directed_plan[r].typed, directed_plan[r].st, directed_plan[r].cnt);

		growing = 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (sorted_copy.size() >= CAPACITY)
					growing = ($urandom_range(99) < 10);
				else if (sorted_copy.size() == 0)
					growing = ($urandom_range(99) >= 10);
				else if ($urandom_range(99) < 8)
					growing = ~growing;
				op = ($urandom_range(99) < (growing ? 75 : 25)) ? CMD_INSERT : CMD_DELETE;
				case ($urandom_range(9))
					0, 1, 2, 3, 4: v = 8'(int'($urandom_range(6)) - 3);
					5, 6, 7: v = 8'($urandom);
					default: begin
						case ($urandom_range(3))
							0: v = 8'h80;
							1: v = 8'h7F;
							2: v = 8'h00;
							default: v = 8'hFF;
						endcase
					end
				endcase
				if (op == CMD_DELETE && sorted_copy.size() > 0 && $urandom_range(99) < 70)
					v = sorted_copy[$urandom_range(sorted_copy.size() - 1)];
				send_word(op, v, idle_by_phase[ph], 1'b0, STAT_INSERTED, 5'd0);
			end
		end
		start <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
